// ----- design/wssm_pkg.sv -----
// Shared types, sizes and decode tables for the weight-stationary systolic array.
`default_nettype none

package wssm_pkg;

  localparam int ARRAY_DIM = 8;
  localparam int LANES     = 4;
  localparam int GROUPS    = ((ARRAY_DIM / LANES) > 0) ? (ARRAY_DIM / LANES) : 1;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int WORD_BYTES = WORD_W / BYTE_W;
  localparam int OP_W       = 2;
  localparam int IDX_W      = 6;
  localparam int IDX_DEPTH  = 1 << IDX_W;

  localparam int IN_TDATA_W  = ((IDX_W + WORD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_W + 1 + 7) / 8) * 8;

  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int LANE_W = $clog2(LANES) + 1;
  localparam int ROW_W  = IDX_W + LANE_W + 1;
  localparam int COL_W  = GRP_W + LANE_W + 1;
  localparam int FLAT_W = ((IDX_W > $clog2(ARRAY_DIM * ARRAY_DIM)) ? IDX_W :
                           $clog2(ARRAY_DIM * ARRAY_DIM)) + LANE_W + 1;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUEUE = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  // Per-cell control: weight write and the wave strobe.
  typedef struct packed {
    logic  step;
    logic  w_we;
    byte_t w_data;
  } pe_ctrl_t;

  // Column group read back after a queue word, indexed by the queued group.
  typedef logic [GRP_W-1:0] grp_tbl_t [IDX_DEPTH];

  function automatic grp_tbl_t build_grp_tbl();
    grp_tbl_t t;
    for (int i = 0; i < IDX_DEPTH; i++) begin
      t[i] = GRP_W'((i + 1) % GROUPS);
    end
    return t;
  endfunction

  localparam grp_tbl_t GRP_TBL = build_grp_tbl();

  // Byte of a word for a lane; lane 0 sits in the top used byte.
  function automatic byte_t lane_byte(logic [WORD_W-1:0] w, int lane);
    int sh;
    sh = LANES - 1 - lane;
    if (sh >= WORD_BYTES) begin
      return '0;
    end
    return w[BYTE_W*sh +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

// ----- design/wssm_pe.sv -----
// One processing cell: stationary weight, activation pass-through and 8-bit partial sum.
`default_nettype none

module wssm_pe import wssm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  pe_ctrl_t ctrl,
  input  byte_t    act_in,
  input  byte_t    psum_in,
  output byte_t    act_q,
  output byte_t    psum_q,
  output byte_t    psum_mac
);

  byte_t                weight_r;
  byte_t                act_r;
  byte_t                psum_r;
  logic [2*BYTE_W-1:0]  prod;

  // Only the low byte survives, so signedness does not matter here.
  assign prod     = act_in * weight_r;
  assign psum_mac = prod[BYTE_W-1:0] + psum_in;

  assign act_q  = act_r;
  assign psum_q = psum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
      act_r    <= '0;
      psum_r   <= '0;
    end else begin
      if (ctrl.w_we) begin
        weight_r <= ctrl.w_data;
      end
      if (ctrl.step) begin
        act_r  <= act_in;
        psum_r <= psum_mac;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/wssm_in_row.sv -----
// Input skew line for one array row, feeding the row's first cell.
`default_nettype none

module wssm_in_row import wssm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 place_en,
  input  logic [ARRAY_DIM-1:0] place_sel,
  input  byte_t                place_data,
  output byte_t                feed
);

  byte_t skew_r   [ARRAY_DIM];
  byte_t cur      [ARRAY_DIM];
  byte_t skew_nxt [ARRAY_DIM];

  always_comb begin
    for (int c = 0; c < ARRAY_DIM; c++) begin
      cur[c] = (place_en && place_sel[c]) ? place_data : skew_r[c];
    end
    // The first entry keeps its value across a shift.
    for (int c = 0; c < ARRAY_DIM; c++) begin
      if (step && (c > 0)) begin
        skew_nxt[c] = cur[c-1];
      end else begin
        skew_nxt[c] = cur[c];
      end
    end
  end

  assign feed = cur[ARRAY_DIM-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < ARRAY_DIM; c++) begin
        skew_r[c] <= '0;
      end
    end else begin
      skew_r <= skew_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/wssm_out_col.sv -----
// Output skew line for one array column, with its diagonal tap.
`default_nettype none

module wssm_out_col import wssm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  byte_t                psum_last,
  input  logic [ARRAY_DIM-1:0] read_sel,
  output byte_t                diag
);

  byte_t out_r   [ARRAY_DIM];
  byte_t out_nxt [ARRAY_DIM];

  always_comb begin
    for (int k = 0; k < ARRAY_DIM; k++) begin
      if (!step) begin
        out_nxt[k] = out_r[k];
      end else if (k == 0) begin
        out_nxt[k] = psum_last;
      end else begin
        out_nxt[k] = out_r[k-1];
      end
    end
    diag = '0;
    for (int k = 0; k < ARRAY_DIM; k++) begin
      diag = diag | (out_nxt[k] & {BYTE_W{read_sel[k]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ARRAY_DIM; k++) begin
        out_r[k] <= '0;
      end
    end else begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/weight_stationary_systolic_matmul.sv -----
// Top level of the weight-stationary systolic array with stream ports.
`default_nettype none

// A square grid of cells, each holding one signed 8-bit weight, an activation
// register and an 8-bit partial sum. Every accepted word with a valid code is one
// action: load LANES weights, queue one input column group (and read back one
// deskewed output group), or queue the last group, run one multiply-accumulate
// wave across the whole grid and read back group 0. A new word is taken every
// cycle; while a result word waits, in_tready follows out_tready. Its result word
// is registered at the accepting edge, so out_tvalid rises in the next cycle. The
// longest path runs from the input word through the lane decode, one 8x8 multiply
// and byte add in a cell, and the output tap and group select into the output
// register. Partial sums move only one row per wave, so no path crosses more than
// one cell. Only the low byte of every product and sum is kept. nonzero_tile
// reports whether a nonzero weight word was loaded since the last step.
module weight_stationary_systolic_matmul import wssm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // index, word, zero padding
  input  logic [OP_W-1:0]        in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // result_word, nonzero_tile, zero padding
);

  logic                 in_acc;
  logic [IDX_W-1:0]     index;
  logic [WORD_W-1:0]    word;
  logic                 do_load;
  logic                 do_queue;
  logic                 do_step;
  logic [IDX_W-1:0]     place_grp;
  logic [GRP_W-1:0]     read_grp;
  logic [ROW_W-1:0]     lane_row [LANES];
  logic [COL_W-1:0]     lane_col [LANES];
  byte_t                lane_in  [LANES];
  byte_t                lane_out [LANES];
  logic                 place_en   [ARRAY_DIM];
  byte_t                place_data [ARRAY_DIM];
  pe_ctrl_t             pe_ctrl  [ARRAY_DIM][ARRAY_DIM];
  byte_t                feed     [ARRAY_DIM];
  byte_t                act_q    [ARRAY_DIM][ARRAY_DIM];
  byte_t                psum_q   [ARRAY_DIM][ARRAY_DIM];
  byte_t                psum_mac [ARRAY_DIM][ARRAY_DIM];
  byte_t                diag     [ARRAY_DIM];
  logic [WORD_W-1:0]    result;
  logic                 nz_r;
  logic                 nz_nxt;
  logic                 out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign index     = in_tdata[IDX_W-1:0];
  assign word      = in_tdata[IDX_W +: WORD_W];

  always_comb begin
    do_load  = 1'b0;
    do_queue = 1'b0;
    do_step  = 1'b0;
    unique case (op_t'(in_tuser))
      OP_LOAD:  do_load  = in_acc;
      OP_QUEUE: do_queue = in_acc;
      OP_STEP:  do_step  = in_acc;
      default:  ;
    endcase
  end

  // Drop an input group onto the anti-diagonal of the input skew store.
  always_comb begin
    place_grp = do_step ? IDX_W'(GROUPS - 1) : index;
    for (int i = 0; i < LANES; i++) begin
      lane_in[i]  = lane_byte(word, i);
      lane_row[i] = ROW_W'(int'(place_grp) * LANES + i);
    end
    for (int r = 0; r < ARRAY_DIM; r++) begin
      place_en[r]   = 1'b0;
      place_data[r] = '0;
      for (int i = 0; i < LANES; i++) begin
        if ((do_queue || do_step) && (lane_row[i] == ROW_W'(r))) begin
          place_en[r]   = 1'b1;
          place_data[r] = lane_in[i];
        end
      end
    end
  end

  // Weight writes: LANES consecutive flat elements starting at index.
  always_comb begin
    for (int r = 0; r < ARRAY_DIM; r++) begin
      for (int c = 0; c < ARRAY_DIM; c++) begin
        pe_ctrl[r][c].step   = do_step;
        pe_ctrl[r][c].w_we   = 1'b0;
        pe_ctrl[r][c].w_data = '0;
        for (int i = 0; i < LANES; i++) begin
          if (do_load &&
              (FLAT_W'(int'(index) + i) == FLAT_W'(r * ARRAY_DIM + c))) begin
            pe_ctrl[r][c].w_we   = 1'b1;
            pe_ctrl[r][c].w_data = lane_in[i];
          end
        end
      end
    end
  end

  always_comb begin
    if (do_load && (word != '0)) begin
      nz_nxt = 1'b1;
    end else if (do_step) begin
      nz_nxt = 1'b0;
    end else begin
      nz_nxt = nz_r;
    end
  end

  genvar gr, gc;
  generate
    for (gr = 0; gr < ARRAY_DIM; gr++) begin : g_row
      localparam logic [ARRAY_DIM-1:0] PLACE_SEL = ARRAY_DIM'(1) << (ARRAY_DIM - 1 - gr);

      wssm_in_row u_in_row (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (do_step),
        .place_en   (place_en[gr]),
        .place_sel  (PLACE_SEL),
        .place_data (place_data[gr]),
        .feed       (feed[gr])
      );

      for (gc = 0; gc < ARRAY_DIM; gc++) begin : g_col
        byte_t act_in;
        byte_t psum_in;

        if (gc == 0) begin : g_act_head
          assign act_in = feed[gr];
        end else begin : g_act_chain
          assign act_in = act_q[gr][gc-1];
        end

        if (gr == 0) begin : g_psum_head
          assign psum_in = '0;
        end else begin : g_psum_chain
          assign psum_in = psum_q[gr-1][gc];
        end

        wssm_pe u_pe (
          .clk      (clk),
          .rst_n    (rst_n),
          .ctrl     (pe_ctrl[gr][gc]),
          .act_in   (act_in),
          .psum_in  (psum_in),
          .act_q    (act_q[gr][gc]),
          .psum_q   (psum_q[gr][gc]),
          .psum_mac (psum_mac[gr][gc])
        );
      end
    end

    for (gc = 0; gc < ARRAY_DIM; gc++) begin : g_out
      localparam logic [ARRAY_DIM-1:0] READ_SEL = ARRAY_DIM'(1) << (ARRAY_DIM - 1 - gc);

      wssm_out_col u_out_col (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (do_step),
        .psum_last (psum_mac[ARRAY_DIM-1][gc]),
        .read_sel  (READ_SEL),
        .diag      (diag[gc])
      );
    end
  endgenerate

  // Deskewed read of one output group; columns past the grid read zero.
  always_comb begin
    read_grp = do_queue ? GRP_TBL[index] : '0;
    result   = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_col[i] = COL_W'(int'(read_grp) * LANES + i);
      lane_out[i] = '0;
      for (int c = 0; c < ARRAY_DIM; c++) begin
        if (lane_col[i] == COL_W'(c)) begin
          lane_out[i] = diag[c];
        end
      end
      if ((LANES - 1 - i) < WORD_BYTES) begin
        result[BYTE_W*(LANES-1-i) +: BYTE_W] = lane_out[i];
      end
    end
    if (!(do_queue || do_step)) begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      nz_r <= nz_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_tdata_r <= {(OUT_TDATA_W - WORD_W - 1)'(0), nz_nxt, result};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ----- bench/weight_stationary_systolic_matmul_tb.sv -----
// Self-checking testbench for the weight-stationary systolic array with stream ports.
`timescale 1ns / 100ps

module weight_stationary_systolic_matmul_tb import wssm_pkg::*; ();

  // Action code outside the decoded set; the block must leave its state alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL  = 80;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic              nonzero_tile;
  } tile_result_t;

  // Shadow copy of the array that predicts each result word and checks it.
  class matmul_scoreboard;
    byte_t        weights  [ARRAY_DIM*ARRAY_DIM];
    byte_t        skew_in  [ARRAY_DIM][ARRAY_DIM];
    byte_t        acts     [ARRAY_DIM][ARRAY_DIM];
    byte_t        sums     [ARRAY_DIM][ARRAY_DIM];
    byte_t        skew_out [ARRAY_DIM][ARRAY_DIM];
    logic         tile_nonzero;
    tile_result_t expected_q[$];
    int unsigned  failures;

    function new();
      for (int r = 0; r < ARRAY_DIM; r++) begin
        for (int c = 0; c < ARRAY_DIM; c++) begin
          weights[r*ARRAY_DIM+c] = '0;
          skew_in[r][c]  = '0;
          acts[r][c]     = '0;
          sums[r][c]     = '0;
          skew_out[r][c] = '0;
        end
      end
      tile_nonzero = 1'b0;
      failures     = 0;
    endfunction

    function byte_t lane_of(logic [WORD_W-1:0] w, int lane);
      int sh;
      sh = LANES - 1 - lane;
      if (sh >= WORD_BYTES) return '0;
      return w[BYTE_W*sh +: BYTE_W];
    endfunction

    // Lanes of a column group land on the anti-diagonal of the input skew.
    function void place_group(int grp, logic [WORD_W-1:0] w);
      int row;
      for (int i = 0; i < LANES; i++) begin
        row = grp * LANES + i;
        if (row < ARRAY_DIM) skew_in[row][ARRAY_DIM-1-row] = lane_of(w, i);
      end
    endfunction

    function logic [WORD_W-1:0] read_group(int start);
      logic [63:0] acc;
      int          c;
      acc = '0;
      for (int i = 0; i < LANES; i++) begin
        c = start + i;
        if (c < ARRAY_DIM)
          acc |= 64'(skew_out[ARRAY_DIM-1-c][c]) << (BYTE_W * (LANES - 1 - i));
      end
      return acc[WORD_W-1:0];
    endfunction

    function void run_wave();
      for (int r = 0; r < ARRAY_DIM; r++) begin
        acts[r][0] = skew_in[r][ARRAY_DIM-1];
        for (int c = ARRAY_DIM - 1; c > 0; c--) skew_in[r][c] = skew_in[r][c-1];
      end
      // Bottom row first, so each row adds the sum its upper neighbor held before the wave.
      for (int r = ARRAY_DIM - 1; r >= 0; r--) begin
        for (int c = 0; c < ARRAY_DIM; c++) begin
          sums[r][c] = acts[r][c] * weights[r*ARRAY_DIM+c] + ((r == 0) ? 8'd0 : sums[r-1][c]);
        end
      end
      for (int r = 0; r < ARRAY_DIM; r++) begin
        for (int c = ARRAY_DIM - 1; c > 0; c--) acts[r][c] = acts[r][c-1];
      end
      for (int c = 0; c < ARRAY_DIM; c++) begin
        for (int r = ARRAY_DIM - 1; r > 0; r--) skew_out[r][c] = skew_out[r-1][c];
        skew_out[0][c] = sums[ARRAY_DIM-1][c];
      end
    endfunction

    function void note_word(logic [OP_W-1:0] action, logic [IDX_W-1:0] index,
                            logic [WORD_W-1:0] w);
      tile_result_t res;
      res.result_word = '0;
      case (action)
        OP_LOAD: begin
          for (int i = 0; i < LANES; i++) begin
            if (int'(index) + i < ARRAY_DIM * ARRAY_DIM)
              weights[int'(index) + i] = lane_of(w, i);
          end
          if (w != '0) tile_nonzero = 1'b1;
        end
        OP_QUEUE: begin
          place_group(int'(index), w);
          res.result_word = read_group(((int'(index) + 1) % GROUPS) * LANES);
        end
        OP_STEP: begin
          tile_nonzero = 1'b0;
          place_group(GROUPS - 1, w);
          run_wave();
          res.result_word = read_group(0);
        end
        default: ;
      endcase
      res.nonzero_tile = tile_nonzero;
      expected_q.push_back(res);
    endfunction

    function void check_word(logic [WORD_W-1:0] result_word, logic nonzero_tile);
      tile_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation waiting: result_word %h", result_word);
        failures++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (result_word !== exp_res.result_word) begin
        $error("result_word: expected %h, actual %h", exp_res.result_word, result_word);
        failures++;
      end
      if (nonzero_tile !== exp_res.nonzero_tile) begin
        $error("nonzero_tile: expected %b, actual %b", exp_res.nonzero_tile, nonzero_tile);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  matmul_scoreboard sb = new();
  bit          idle_on = 1'b1;
  bit          long_stall_req = 1'b0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;

  weight_stationary_systolic_matmul i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Both handshakes are sampled in one process so a word is always noted before it is read back.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_word(in_tuser, in_tdata[IDX_W-1:0], in_tdata[IDX_W +: WORD_W]);
      if (out_tvalid && out_tready)
        sb.check_word(out_tdata[WORD_W-1:0], out_tdata[WORD_W]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input int idx,
                           input logic [WORD_W-1:0] w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({w, IDX_W'(idx)});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Random word with extra weight on zero, all ones and the signed byte extremes.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {4{$urandom_range(0, 1) ? 8'h80 : 8'h7f}};
      default: return $urandom;
    endcase
  endfunction

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A well-formed pass: optionally a full weight load, then waves of column groups.
  task automatic run_tile(input int waves);
    if ($urandom_range(0, 3) == 0) begin
      for (int e = 0; e < ARRAY_DIM * ARRAY_DIM; e += LANES)
        send_word(OP_LOAD, e, ($urandom_range(0, 7) == 0) ? '0 : pick_word());
    end
    for (int k = 0; k < waves; k++) begin
      for (int g = 0; g < GROUPS - 1; g++) send_word(OP_QUEUE, g, pick_word());
      send_word(OP_STEP, $urandom_range(0, 63), pick_word());
    end
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = OP_LOAD;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: index and byte extremes, lanes past the grid, every action.
    send_word(OP_STEP, 0, '0);
    send_word(OP_LOAD, 0, 32'h7f80_01ff);
    send_word(OP_LOAD, 60, 32'hffff_ffff);
    send_word(OP_LOAD, 61, 32'h1234_5678);
    send_word(OP_LOAD, 63, 32'h8000_0001);
    send_word(OP_QUEUE, 0, 32'h807f_ff01);
    send_word(OP_QUEUE, 1, 32'hffff_ffff);
    send_word(OP_QUEUE, 63, 32'haaaa_5555);
    send_word(OP_UNUSED, 42, 32'hdead_beef);
    send_word(OP_STEP, 63, 32'h0102_0304);
    send_word(OP_LOAD, 4, '0);
    send_word(OP_STEP, 21, 32'hffff_ffff);
    send_word(OP_LOAD, 8, 32'h7f7f_7f7f);
    send_word(OP_LOAD, 4, '0);
    send_word(OP_UNUSED, 0, '0);
    send_word(OP_QUEUE, 2, 32'h8080_8080);
    send_word(OP_STEP, 0, 32'h8080_8080);
    for (int k = 0; k < 6; k++) send_word(OP_STEP, k, 32'h0101_0101 << k);

    // Hold the result side off while words keep coming, then let everything drain.
    long_stall_req = 1'b1;
    run_tile(15);
    in_tvalid <= 1'b0;
    drain_results();

    while (words_sent < 340) begin
      if ($urandom_range(0, 9) < 7) begin
        run_tile($urandom_range(1, 12));
      end else begin
        for (int k = $urandom_range(1, 8); k > 0; k--)
          send_word(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63), pick_word());
      end
    end

    idle_on = 1'b0;
    while (words_sent < 400) run_tile($urandom_range(1, 8));
    in_tvalid <= 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
